>>> design/ptl_pkg.sv
// Shared types and operation codes for the pc to line table lookup block.
`timescale 1ns / 1ps
`default_nettype none

package ptl_pkg;

    // Operation codes carried in the op field.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam int unsigned PC_W   = 16;
    localparam int unsigned LINE_W = 16;
    localparam int unsigned RES_W  = LINE_W + 1;

    // Answer given when no stored entry starts at or below the query pc.
    localparam logic signed [RES_W-1:0] LINE_NONE = '1;

    // One table entry as it sits in the memory.
    typedef struct packed {
        logic [PC_W-1:0]   first_pc;
        logic [LINE_W-1:0] line;
    } entry_t;

    // Request from the control path to the scan unit.
    typedef struct packed {
        logic            start;
        logic [PC_W-1:0] pc;
    } scan_req_t;

    // Completion report from the scan unit.
    typedef struct packed {
        logic                    done;
        logic signed [RES_W-1:0] line;
    } scan_rsp_t;

endpackage

`default_nettype wire

>>> design/ptl_mem.sv
// Entry memory of the line number table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ptl_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire ptl_pkg::entry_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output ptl_pkg::entry_t      rd_data
);
    import ptl_pkg::*;

    entry_t mem [0:DEPTH-1];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/ptl_scan.sv
// Scan unit: walks the stored entries once and keeps the best match for a query pc.
`timescale 1ns / 1ps
`default_nettype none

module ptl_scan #(
    parameter int unsigned CW = 9,
    parameter int unsigned AW = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptl_pkg::scan_req_t req,
    input  wire logic [CW-1:0]      count,
    output logic                    rd_en,
    output logic [AW-1:0]           rd_addr,
    input  wire ptl_pkg::entry_t    rd_data,
    output ptl_pkg::scan_rsp_t      rsp
);
    import ptl_pkg::*;

    logic              busy_reg;
    logic              chk_reg;
    logic [CW-1:0]     issue_reg;
    logic [CW-1:0]     cnt_reg;
    logic [PC_W-1:0]   qpc_reg;
    logic              found_reg;
    logic [PC_W-1:0]   best_pc_reg;
    logic [LINE_W-1:0] best_line_reg;
    logic              take;

    assign rd_en   = busy_reg && (issue_reg < cnt_reg);
    assign rd_addr = issue_reg[AW-1:0];

    // A strictly larger start pc is needed to replace the current best, so the
    // earliest stored entry wins when start pcs are equal.
    assign take = chk_reg && (rd_data.first_pc <= qpc_reg) &&
                  (!found_reg || (rd_data.first_pc > best_pc_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            chk_reg   <= 1'b0;
            issue_reg <= '0;
            found_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            chk_reg   <= 1'b0;
            issue_reg <= '0;
            found_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            chk_reg <= rd_en;
            if (rd_en)
            begin
                issue_reg <= issue_reg + CW'(1);
            end
            if (take)
            begin
                found_reg <= 1'b1;
            end
            if (rsp.done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            qpc_reg <= req.pc;
            cnt_reg <= count;
        end
        if (take)
        begin
            best_pc_reg   <= rd_data.first_pc;
            best_line_reg <= rd_data.line;
        end
    end

    assign rsp.done = busy_reg && !rd_en && !chk_reg;
    assign rsp.line = found_reg ? $signed({1'b0, best_line_reg}) : LINE_NONE;

endmodule

`default_nettype wire

>>> design/pc_to_line_table_lookup.sv
// Top level of the pc to line table lookup block.
`timescale 1ns / 1ps
`default_nettype none

// Line number table engine. A start word empties the table and checks its declared
// byte length against four bytes per entry plus two; an append word stores one
// (start pc, line) pair, or sets the overflow flag when the table is full; a query
// word returns the line of the entry with the largest start pc not above the query
// pc, the earliest on ties, or -1 if none. Every input word gives exactly one
// output word, carrying the sticky invalid and overflow flags. A query reads the
// stored entries in turn, since the entry memory delivers one entry per cycle
// through its single read port. One word is worked on at a time; a finished word
// waits in the output register while the next input word is taken.
module pc_to_line_table_lookup #(
    parameter int unsigned MAX_ENTRIES = 256
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      op,
    input  wire logic [15:0]                     entry_count,
    input  wire logic [31:0]                     byte_length,
    input  wire logic [ptl_pkg::PC_W-1:0]        entry_start_pc,
    input  wire logic [ptl_pkg::LINE_W-1:0]      entry_line,
    input  wire logic [ptl_pkg::PC_W-1:0]        query_pc,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic signed [ptl_pkg::RES_W-1:0]     line_result,
    output logic                                 table_invalid,
    output logic                                 table_overflow
);
    import ptl_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CW-1:0]           count_reg;
    logic                    invalid_reg;
    logic                    overflow_reg;
    logic signed [RES_W-1:0] pend_line_reg;
    logic                    out_valid_reg;
    logic signed [RES_W-1:0] line_result_reg;
    logic                    table_invalid_reg;
    logic                    table_overflow_reg;

    logic      accept;
    logic      room;
    logic      length_ok;
    logic      emit;
    logic      wr_en;
    entry_t    wr_data;
    logic      rd_en;
    logic [AW-1:0] rd_addr;
    entry_t    rd_data;
    scan_req_t scan_req;
    scan_rsp_t scan_rsp;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign room      = (count_reg < CW'(MAX_ENTRIES));
    // entry_count * 4 + 2 fits in 18 bits, so it is formed by concatenation.
    assign length_ok = (byte_length == {14'd0, entry_count, 2'b10});
    assign emit      = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    assign wr_en            = accept && (op == OP_APPEND) && room;
    assign wr_data.first_pc = entry_start_pc;
    assign wr_data.line     = entry_line;

    assign scan_req.start = accept && (op == OP_QUERY);
    assign scan_req.pc    = query_pc;

    ptl_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ptl_scan #(
        .CW (CW),
        .AW (AW)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scan_req),
        .count   (count_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rsp     (scan_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (op == OP_QUERY) ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            invalid_reg   <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (op == OP_START))
            begin
                count_reg <= '0;
                if (!length_ok)
                begin
                    invalid_reg <= 1'b1;
                end
            end
            if (accept && (op == OP_APPEND))
            begin
                if (room)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_line_reg <= '0;
        end
        else if ((state_reg == S_SCAN) && scan_rsp.done)
        begin
            pend_line_reg <= scan_rsp.line;
        end
        if (emit)
        begin
            line_result_reg    <= pend_line_reg;
            table_invalid_reg  <= invalid_reg;
            table_overflow_reg <= overflow_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign line_result    = line_result_reg;
    assign table_invalid  = table_invalid_reg;
    assign table_overflow = table_overflow_reg;

`ifndef SYNTHESIS
    a_invalid_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        invalid_reg |=> invalid_reg)
        else $error("invalid flag cleared without reset");

    a_overflow_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared without reset");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("stored entry count beyond table size");

    a_scan_only_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
        scan_rsp.done |-> (state_reg == S_SCAN))
        else $error("scan finished outside a query");

    a_no_write_during_scan : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_IDLE))
        else $error("table written while a query is in flight");
`endif

endmodule

`default_nettype wire
